FILE: hdl/ihexld_pkg.sv
// ----------------------------------------------------------------------------
// ihexld_pkg
// Shared types, codes and the hex digit decoder of the hex record loader.
// ----------------------------------------------------------------------------
`default_nettype none

package ihexld_pkg;

    localparam int IMG_END_W = 17;

    localparam logic [7:0] COLON_CHAR  = 8'h3A;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // record byte positions
    localparam logic [6:0] IDX_LENGTH     = 7'd0;
    localparam logic [6:0] IDX_ADDR_HI    = 7'd1;
    localparam logic [6:0] IDX_ADDR_LO    = 7'd2;
    localparam logic [6:0] IDX_KIND       = 7'd3;
    localparam logic [6:0] IDX_DATA       = 7'd4;
    localparam logic [6:0] MIN_RECORD     = 7'd5;
    localparam logic [6:0] BYTE_INDEX_MAX = 7'd127;

    localparam logic [7:0] KIND_DATA   = 8'h00;
    localparam logic [7:0] KIND_EOF    = 8'h01;
    localparam logic [7:0] KIND_SEG    = 8'h02;
    localparam logic [7:0] SEG_LENGTH  = 8'd2;

    typedef enum logic [3:0] {
        PH_COLON = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_END      = 3'd1,
        ST_FORMAT   = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_SEG_LEN  = 3'd4,
        ST_BAD_KIND = 3'd5,
        ST_DUP      = 3'd6,
        ST_RANGE    = 3'd7
    } status_t;

    // what the parser hands to the memory stage for one character
    typedef struct packed {
        logic                 finish;
        status_t              base;
        logic                 store;
        logic [IMG_END_W-1:0] addr;
        logic [7:0]           data;
    } parse_res_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/intel_hex_record_loader.sv
// ----------------------------------------------------------------------------
// intel_hex_record_loader
// Loads hex records into a byte image memory and serves image reads.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one word per cycle: func 0 feeds
// one line character (char_code, line_end on the last one of a line), func 1
// reads the image byte at read_address.
// Output channel (out_valid/out_stall) returns one word per input word: the
// load status, the read byte (zero for a feed or a read beyond the image)
// and one past the highest image address written.
// An accepted word passes the memory check stage, then the output register,
// which raises out_valid; one word is taken every cycle while in_stall is low.
// The image memory sees one read when a word is accepted and one write when
// a data byte leaves the memory check stage; the duplicate check of a data
// byte reads when its second digit is accepted and writes when it leaves
// that stage, which a stalled output can delay.
// After reset the image is swept to 0xFF, one byte per cycle, over all
// MEM_BYTES addresses; in_stall stays high during the sweep.
// A stalled output holds its word; the stall reaches in_stall once the
// internal stage is full, so nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_loader #(
    parameter int MEM_BYTES      = 65536,
    parameter int MAX_LINE_CHARS = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  char_code,
    input  wire logic        line_end,
    input  wire logic [15:0] read_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       read_data,
    output logic [16:0]      image_end
);

    import ihexld_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    // sweep
    logic           clearing_reg;
    logic [AW-1:0]  clr_addr_reg;

    // handshakes
    logic           accept;
    logic           s1_adv;

    // parse stage
    parse_res_t     pres;

    // memory check stage
    logic           s1_valid_reg;
    logic           s1_func_reg;
    logic           s1_rd_range_reg;
    parse_res_t     s1_res_reg;
    logic           byp_reg;
    logic [7:0]     byp_data_reg;

    status_t        st_reg, st_next;
    logic           dup_reg, dup_next;
    logic           range_reg, range_next;
    logic [16:0]    high_reg, high_next;

    // ram
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_q;
    logic [7:0]     mem_byte;
    logic           do_write;

    // output register
    logic           out_valid_reg;
    status_t        out_st_reg;
    logic [7:0]     out_data_reg;
    logic [16:0]    out_end_reg;

    assign s1_adv   = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = clearing_reg | (s1_valid_reg & out_valid_reg & out_stall);
    assign accept   = in_valid & ~in_stall;

    ihexld_parser #(
        .MAX_LINE_CHARS(MAX_LINE_CHARS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed_en   (accept & ~func),
        .char_code (char_code),
        .line_end  (line_end),
        .res       (pres)
    );

    assign ram_raddr = func ? read_address[AW-1:0] : pres.addr[AW-1:0];
    assign mem_byte  = byp_reg ? byp_data_reg : ram_q;

    // memory check and line end decision
    always_comb
    begin
        st_next    = st_reg;
        dup_next   = dup_reg;
        range_next = range_reg;
        high_next  = high_reg;
        do_write   = 1'b0;
        if (s1_valid_reg && !s1_func_reg && st_reg == ST_OK)
        begin
            if (s1_res_reg.store && !dup_reg && !range_reg)
            begin
                if (s1_res_reg.addr >= 17'(MEM_BYTES))
                begin
                    range_next = 1'b1;
                end
                else if (mem_byte != ERASED_BYTE)
                begin
                    dup_next = 1'b1;
                end
                else
                begin
                    do_write = 1'b1;
                    if (s1_res_reg.addr + 17'd1 > high_reg)
                    begin
                        high_next = s1_res_reg.addr + 17'd1;
                    end
                end
            end
            if (s1_res_reg.finish)
            begin
                if (s1_res_reg.base != ST_OK)
                begin
                    st_next = s1_res_reg.base;
                end
                else if (dup_next)
                begin
                    st_next = ST_DUP;
                end
                else if (range_next)
                begin
                    st_next = ST_RANGE;
                end
                dup_next   = 1'b0;
                range_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = ERASED_BYTE;
        end
        else
        begin
            ram_we    = s1_adv & do_write;
            ram_waddr = s1_res_reg.addr[AW-1:0];
            ram_wdata = s1_res_reg.data;
        end
    end

    ihexld_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_image (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MEM_BYTES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            st_reg       <= ST_OK;
            dup_reg      <= 1'b0;
            range_reg    <= 1'b0;
            high_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                st_reg    <= st_next;
                dup_reg   <= dup_next;
                range_reg <= range_next;
                high_reg  <= high_next;
            end
        end
    end

    // stage payload; write forwarding covers a read of the byte being written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg     <= func;
            s1_rd_range_reg <= {1'b0, read_address} >= 17'(MEM_BYTES);
            s1_res_reg      <= pres;
            byp_reg         <= ram_we & (ram_waddr == ram_raddr);
            byp_data_reg    <= ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_st_reg   <= st_next;
            out_data_reg <= (s1_func_reg && !s1_rd_range_reg) ? mem_byte : 8'h00;
            out_end_reg  <= high_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign read_data = out_data_reg;
    assign image_end = out_end_reg;

endmodule

`default_nettype wire

FILE: hdl/ihexld_ram.sv
// ----------------------------------------------------------------------------
// ihexld_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ihexld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ihexld_parser.sv
// ----------------------------------------------------------------------------
// ihexld_parser
// Character level record parser: colon, digit pairing, header fields,
// format and length checks and the line end decision without memory checks.
// ----------------------------------------------------------------------------
`default_nettype none

module ihexld_parser #(
    parameter int MAX_LINE_CHARS = 255
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   feed_en,
    input  wire logic [7:0]             char_code,
    input  wire logic                   line_end,
    output ihexld_pkg::parse_res_t      res
);

    import ihexld_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic [6:0]  byte_idx_reg, byte_idx_next;
    logic [7:0]  rec_len_reg, rec_len_next;
    logic [15:0] rec_addr_reg, rec_addr_next;
    logic [7:0]  rec_kind_reg, rec_kind_next;
    logic        fmt_reg, fmt_next;
    logic        len_reg, len_next;
    logic        halted_reg, halted_next;

    logic        active;
    logic [4:0]  digit;
    logic [8:0]  pos;
    logic        pos_long;
    logic [6:0]  data_idx;
    status_t     base;

    assign active   = feed_en & ~halted_reg;
    assign digit    = hex_digit(char_code);
    assign pos      = 9'd2 + 9'({byte_idx_reg, 1'b0}) + 9'(phase_reg == PH_LOW);
    assign pos_long = pos > 9'(MAX_LINE_CHARS);
    assign data_idx = byte_idx_reg - IDX_DATA;

    always_comb
    begin
        phase_next    = phase_reg;
        nibble_next   = nibble_reg;
        byte_idx_next = byte_idx_reg;
        rec_len_next  = rec_len_reg;
        rec_addr_next = rec_addr_reg;
        rec_kind_next = rec_kind_reg;
        fmt_next      = fmt_reg;
        len_next      = len_reg;
        halted_next   = halted_reg;
        base          = ST_OK;

        res.finish = 1'b0;
        res.base   = ST_OK;
        res.store  = 1'b0;
        res.addr   = IMG_END_W'(rec_addr_reg) + IMG_END_W'(data_idx);
        res.data   = {nibble_reg, digit[3:0]};

        if (active)
        begin
            case (phase_reg)
                PH_COLON:
                begin
                    if (char_code == COLON_CHAR)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        fmt_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_HIGH, PH_LOW:
                begin
                    if (pos_long)
                    begin
                        len_next = 1'b1;
                    end
                    if (!digit[4])
                    begin
                        fmt_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (phase_reg == PH_HIGH)
                    begin
                        nibble_next = digit[3:0];
                        phase_next  = PH_LOW;
                    end
                    else
                    begin
                        case (byte_idx_reg)
                            IDX_LENGTH:  rec_len_next  = res.data;
                            IDX_ADDR_HI: rec_addr_next = {res.data, 8'h00};
                            IDX_ADDR_LO: rec_addr_next = {rec_addr_reg[15:8], res.data};
                            IDX_KIND:    rec_kind_next = res.data;
                            default:
                            begin
                                // data byte, flags from earlier in the line block it
                                res.store = ({1'b0, data_idx} < rec_len_reg)
                                          & (rec_kind_reg == KIND_DATA)
                                          & ~fmt_reg & ~len_reg & ~pos_long;
                            end
                        endcase
                        if (byte_idx_reg < BYTE_INDEX_MAX)
                        begin
                            byte_idx_next = byte_idx_reg + 7'd1;
                        end
                        else
                        begin
                            len_next = 1'b1;
                        end
                        phase_next = PH_HIGH;
                    end
                end
                PH_SKIP:
                begin
                end
                default:
                begin
                end
            endcase

            if (line_end)
            begin
                if (fmt_next || phase_next == PH_LOW || phase_next == PH_SKIP)
                begin
                    base = ST_FORMAT;
                end
                else if (len_next || byte_idx_next < MIN_RECORD ||
                         8'({1'b0, byte_idx_next} - {1'b0, MIN_RECORD}) != rec_len_next)
                begin
                    base = ST_LENGTH;
                end
                else if (rec_kind_next == KIND_SEG)
                begin
                    base = (rec_len_next != SEG_LENGTH) ? ST_SEG_LEN : ST_BAD_KIND;
                end
                else if (rec_kind_next == KIND_EOF)
                begin
                    base = ST_END;
                end
                else if (rec_kind_next != KIND_DATA)
                begin
                    base = ST_BAD_KIND;
                end
                res.finish    = 1'b1;
                res.base      = base;
                halted_next   = (base != ST_OK);
                phase_next    = PH_COLON;
                nibble_next   = '0;
                byte_idx_next = '0;
                rec_len_next  = '0;
                rec_addr_next = '0;
                rec_kind_next = '0;
                fmt_next      = 1'b0;
                len_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COLON;
            nibble_reg   <= '0;
            byte_idx_reg <= '0;
            rec_len_reg  <= '0;
            rec_addr_reg <= '0;
            rec_kind_reg <= '0;
            fmt_reg      <= 1'b0;
            len_reg      <= 1'b0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            nibble_reg   <= nibble_next;
            byte_idx_reg <= byte_idx_next;
            rec_len_reg  <= rec_len_next;
            rec_addr_reg <= rec_addr_next;
            rec_kind_reg <= rec_kind_next;
            fmt_reg      <= fmt_next;
            len_reg      <= len_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ihexld_checker.sv
// ----------------------------------------------------------------------------
// ihexld_checker
// Port level checks of the hex record loader, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ihexld_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [7:0]  read_data,
    input wire logic [16:0] image_end
);

    import ihexld_pkg::*;

    logic        seen_reg;
    logic [2:0]  last_st_reg;
    logic [16:0] last_end_reg;
    logic        take;

    assign take = out_valid & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_st_reg  <= '0;
            last_end_reg <= '0;
        end
        else if (take)
        begin
            seen_reg     <= 1'b1;
            last_st_reg  <= status;
            last_end_reg <= image_end;
        end
    end

    // a final status sticks for every later word
    a_status_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (take && seen_reg && last_st_reg != ST_OK) |-> status == last_st_reg)
        else $error("load status changed after it was final");

    // the image end only grows
    a_end_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && seen_reg) |-> image_end >= last_end_reg)
        else $error("image end went down");

    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> image_end <= 17'h10000)
        else $error("image end beyond the address space");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                      $stable(read_data) && $stable(image_end)))
        else $error("stalled result word changed");

endmodule

bind intel_hex_record_loader ihexld_checker u_ihexld_checker (.*);

`default_nettype wire
